[hw/rtl/layer_blend_mode_channel_top_assert.svh]
// Assertion macros for the layer blend top level.
`ifndef LAYER_BLEND_MODE_CHANNEL_TOP_ASSERT_SVH
`define LAYER_BLEND_MODE_CHANNEL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define LBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define LBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lbm_pkg.sv]
// Types, constants and helper functions for the layer blend pipeline.
package lbm_pkg;

  // Fixed-point formats.
  localparam int FRAC_W = 15;
  localparam int IN_W = 16;
  localparam int OUT_W = 21;
  localparam int WIDE_W = 24;
  localparam int OP_W = 19;
  localparam int MAG_W = 17;
  localparam int X_W = 32;
  localparam int Q_W = 21;
  localparam int DCMP_W = X_W + Q_W;
  localparam int SQ_X_W = 32;
  localparam int SQ_R_W = 16;
  localparam int SQ_REM_W = 19;
  localparam int HUN_W = 8;
  localparam int MODQ_W = 17;

  // Iteration counts of the shared pipeline.
  localparam int DIV_STEPS = 21;
  localparam int SQRT_STEPS = 16;
  localparam int MOD_STEPS = 8;

  // Modulo epsilon, round(0.0001 * 2^15).
  localparam int EPS_M = ((1 << FRAC_W) + 5000) / 10000;
  localparam int EPS_Q = (EPS_M > 0) ? EPS_M : 1;

  localparam logic signed [OP_W-1:0] ONE_OP = OP_W'(1 << FRAC_W);
  localparam logic signed [OP_W-1:0] HALF_OP = OP_W'(1 << (FRAC_W - 1));
  localparam logic signed [OP_W-1:0] EPS_OP = OP_W'(EPS_Q);
  localparam logic signed [WIDE_W-1:0] ONE_W = WIDE_W'(1 << FRAC_W);
  localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1 << (FRAC_W - 1));
  localparam logic signed [WIDE_W-1:0] OUT_MAX_W = WIDE_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] OUT_MIN_W = -WIDE_W'(1 << (OUT_W - 1));

  typedef enum logic [4:0] {
    MODE_PASS        = 5'd0,
    MODE_MULTIPLY    = 5'd1,
    MODE_DARKEN      = 5'd2,
    MODE_COLORBURN   = 5'd3,
    MODE_LINEARBURN  = 5'd4,
    MODE_LIGHTEN     = 5'd5,
    MODE_SCREEN      = 5'd6,
    MODE_COLORDODGE  = 5'd7,
    MODE_ADD         = 5'd8,
    MODE_OVERLAY     = 5'd9,
    MODE_HARDLIGHT   = 5'd10,
    MODE_SOFTLIGHT   = 5'd11,
    MODE_VIVID       = 5'd12,
    MODE_LINEARLIGHT = 5'd13,
    MODE_PINLIGHT    = 5'd14,
    MODE_MODULO      = 5'd15,
    MODE_DIFFERENCE  = 5'd16,
    MODE_EXCLUSION   = 5'd17,
    MODE_SUBTRACT    = 5'd18,
    MODE_DIVIDE      = 5'd19
  } mode_e;

  typedef struct packed {
    logic [IN_W-1:0] t;
    logic [IN_W-1:0] b;
    mode_e           mode;
  } item_t;

  typedef struct packed {
    logic [MAG_W-1:0] md;
    logic [X_W-1:0]   rem;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             sat;
    logic             dz;
    logic             inv;
  } div_t;

  typedef struct packed {
    logic [SQ_X_W-1:0]   x;
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_R_W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [HUN_W-1:0] rem;
    logic [HUN_W-1:0] hb;
    logic             zero;
  } mod_t;

  typedef struct packed {
    item_t it;
    div_t  dv;
    sqrt_t sq;
    mod_t  md;
  } chain_t;

  // Hundredths remainder back to Q1.15, round(r * 2^15 / 100).
  typedef logic [MODQ_W-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = MODQ_W'((i * (1 << FRAC_W) + 50) / 100);
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();

  // Signed Q product with round to nearest, ties away from zero.
  function automatic logic signed [WIDE_W-1:0] mulq_f(input logic signed [OP_W-1:0] a,
                                                      input logic signed [OP_W-1:0] b);
    logic [OP_W-1:0]   ma;
    logic [OP_W-1:0]   mb;
    logic [2*OP_W-1:0] p;
    logic [2*OP_W-1:0] pr;
    logic              neg;
    neg = a[OP_W-1] ^ b[OP_W-1];
    ma = a[OP_W-1] ? (~a + 1'b1) : a;
    mb = b[OP_W-1] ? (~b + 1'b1) : b;
    p = ma * mb;
    pr = (p + ((2*OP_W)'(1) << (FRAC_W - 1))) >> FRAC_W;
    return neg ? -$signed(WIDE_W'(pr)) : $signed(WIDE_W'(pr));
  endfunction

endpackage

[hw/rtl/lbm_prep.sv]
// Operand preparation: per-mode divider, root and modulo set-up over two stages.
module lbm_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  lbm_pkg::item_t         item_i,
  output logic                   vld_o,
  output lbm_pkg::chain_t        data_o
);

  localparam int OPW = lbm_pkg::OP_W;
  localparam int MAGW = lbm_pkg::MAG_W;
  localparam int XW = lbm_pkg::X_W;
  localparam int HUNW = lbm_pkg::HUN_W;
  localparam int SQXW = lbm_pkg::SQ_X_W;
  localparam int INW = lbm_pkg::IN_W;

  typedef struct packed {
    lbm_pkg::item_t         it;
    logic signed [OPW-1:0]  n;
    logic signed [OPW-1:0]  d;
    logic                   inv;
    logic                   isdiv;
    logic [HUNW-1:0]        ht;
    logic [HUNW-1:0]        hb;
  } p1_t;

  p1_t                   p1_d, p1_q;
  logic                  v1_q;
  lbm_pkg::chain_t       p2_d, p2_q;
  logic                  v2_q;
  logic signed [OPW-1:0] ts, bs;
  logic [MAGW-1:0]       mn, md;
  logic                  dz;
  logic [XW-1:0]         xn;
  logic [INW+7:0]        tprod, bprod;

  // Stage one: pick numerator and divisor and form the hundredths.
  always_comb begin
    ts = $signed({{(OPW-INW){1'b0}}, item_i.t});
    bs = $signed({{(OPW-INW){1'b0}}, item_i.b});
    p1_d.it = item_i;
    p1_d.n = ts;
    p1_d.d = bs;
    p1_d.inv = 1'b0;
    p1_d.isdiv = 1'b1;
    unique case (item_i.mode)
      lbm_pkg::MODE_COLORBURN: begin
        p1_d.n = lbm_pkg::ONE_OP - ts;
        p1_d.inv = 1'b1;
      end
      lbm_pkg::MODE_COLORDODGE: begin
        p1_d.d = lbm_pkg::ONE_OP - bs;
      end
      lbm_pkg::MODE_VIVID: begin
        if (bs > lbm_pkg::HALF_OP) begin
          p1_d.d = (lbm_pkg::ONE_OP <<< 1) - (bs <<< 1);
        end else begin
          p1_d.n = lbm_pkg::ONE_OP - ts;
          p1_d.d = bs <<< 1;
          p1_d.inv = 1'b1;
        end
      end
      lbm_pkg::MODE_DIVIDE: begin
        if (bs < lbm_pkg::EPS_OP) begin
          p1_d.d = lbm_pkg::EPS_OP;
        end else if (bs > lbm_pkg::ONE_OP) begin
          p1_d.d = lbm_pkg::ONE_OP;
        end
      end
      default: begin
        p1_d.isdiv = 1'b0;
      end
    endcase
    tprod = (INW+8)'((INW+8)'(item_i.t) + (INW+8)'(lbm_pkg::EPS_M)) * (INW+8)'(100);
    bprod = (INW+8)'((INW+8)'(item_i.b) + (INW+8)'(lbm_pkg::EPS_M)) * (INW+8)'(100);
    p1_d.ht = HUNW'(tprod >> lbm_pkg::FRAC_W);
    p1_d.hb = HUNW'(bprod >> lbm_pkg::FRAC_W);
  end

  // Stage two: magnitudes, rounded dividend and the overflow test.
  always_comb begin
    mn = p1_q.n[OPW-1] ? MAGW'(-p1_q.n) : MAGW'(p1_q.n);
    md = p1_q.d[OPW-1] ? MAGW'(-p1_q.d) : MAGW'(p1_q.d);
    dz = p1_q.isdiv && (p1_q.d == '0);
    xn = (XW'(mn) << lbm_pkg::FRAC_W) + XW'(md >> 1);
    p2_d.it = p1_q.it;
    p2_d.dv.md = md;
    p2_d.dv.rem = xn;
    p2_d.dv.q = '0;
    p2_d.dv.neg = dz ? p1_q.n[OPW-1] : (p1_q.n[OPW-1] ^ p1_q.d[OPW-1]);
    p2_d.dv.sat = (xn >> lbm_pkg::Q_W) >= XW'(md);
    p2_d.dv.dz = dz;
    p2_d.dv.inv = p1_q.inv;
    p2_d.sq.x = SQXW'(p1_q.it.t) << lbm_pkg::FRAC_W;
    p2_d.sq.rem = '0;
    p2_d.sq.root = '0;
    p2_d.md.rem = p1_q.ht;
    p2_d.md.hb = p1_q.hb;
    p2_d.md.zero = (p1_q.hb == '0);
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  assign vld_o = v2_q;
  assign data_o = p2_q;

endmodule

[hw/rtl/lbm_chain.sv]
// Shared iteration pipeline: one quotient bit a stage, plus one root digit and one modulo step a stage while those run.
module lbm_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  lbm_pkg::chain_t data_i,
  output logic            vld_o,
  output lbm_pkg::chain_t data_o
);

  localparam int N = lbm_pkg::DIV_STEPS;
  localparam int XW = lbm_pkg::X_W;
  localparam int CW = lbm_pkg::DCMP_W;
  localparam int SRW = lbm_pkg::SQ_REM_W;
  localparam int SW = lbm_pkg::SQ_R_W;
  localparam int SXW = lbm_pkg::SQ_X_W;
  localparam int HUNW = lbm_pkg::HUN_W;

  lbm_pkg::chain_t link [N+1];
  lbm_pkg::chain_t stg_q [N];
  logic [N:0]      link_v;
  logic [N-1:0]    vld_q;

  assign link[0] = data_i;
  assign link_v[0] = vld_i;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int DK = N - 1 - j;
    localparam int MK = (j < lbm_pkg::MOD_STEPS) ? (lbm_pkg::MOD_STEPS - 1 - j) : 0;
    localparam bit DO_SQ = (j < lbm_pkg::SQRT_STEPS);
    localparam bit DO_MOD = (j < lbm_pkg::MOD_STEPS);

    lbm_pkg::chain_t  cur, nx;
    logic [CW-1:0]    dsh, drem;
    logic [SRW-1:0]   srem, strial;
    logic [2*HUNW-1:0] msh, mrem;

    assign cur = link[j];

    // One restoring step of each iteration that is still running.
    always_comb begin
      nx = cur;
      dsh = CW'(cur.dv.md) << DK;
      drem = CW'(cur.dv.rem);
      if (drem >= dsh) begin
        nx.dv.rem = XW'(drem - dsh);
        nx.dv.q[DK] = 1'b1;
      end
      srem = {cur.sq.rem[SRW-3:0], cur.sq.x[SXW-1 -: 2]};
      strial = SRW'({cur.sq.root, 2'b01});
      if (DO_SQ) begin
        nx.sq.x = cur.sq.x << 2;
        if (srem >= strial) begin
          nx.sq.rem = srem - strial;
          nx.sq.root = {cur.sq.root[SW-2:0], 1'b1};
        end else begin
          nx.sq.rem = srem;
          nx.sq.root = {cur.sq.root[SW-2:0], 1'b0};
        end
      end
      msh = (2*HUNW)'(cur.md.hb) << MK;
      mrem = (2*HUNW)'(cur.md.rem);
      if (DO_MOD && (mrem >= msh)) begin
        nx.md.rem = HUNW'(mrem - msh);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= link_v[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[j] <= nx;
      end
    end

    assign link[j+1] = stg_q[j];
    assign link_v[j+1] = vld_q[j];
  end

  assign vld_o = link_v[N];
  assign data_o = link[N];

endmodule

[hw/rtl/lbm_combine.sv]
// Products, per-mode result selection and final clamp over five stages.
module lbm_combine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  lbm_pkg::chain_t                  data_i,
  output logic                             vld_o,
  output logic signed [lbm_pkg::OUT_W-1:0] value_o,
  output logic                             sat_o
);

  localparam int OPW = lbm_pkg::OP_W;
  localparam int WW = lbm_pkg::WIDE_W;
  localparam int INW = lbm_pkg::IN_W;
  localparam int SW = lbm_pkg::SQ_R_W;
  localparam int OW = lbm_pkg::OUT_W;

  typedef struct packed {
    lbm_pkg::item_t              it;
    logic signed [WW-1:0]        qs;
    logic                        dz;
    logic                        inv;
    logic [lbm_pkg::HUN_W-1:0]   mrem;
    logic                        mzero;
    logic                        softlow;
    logic signed [OPW-1:0]       pa_a;
    logic signed [OPW-1:0]       pa_b;
    logic signed [OPW-1:0]       pb_a;
    logic signed [OPW-1:0]       pb_b;
  } c1_t;

  typedef struct packed {
    lbm_pkg::item_t              it;
    logic signed [WW-1:0]        qs;
    logic                        dz;
    logic                        inv;
    logic [lbm_pkg::HUN_W-1:0]   mrem;
    logic                        mzero;
    logic                        softlow;
    logic signed [WW-1:0]        pa;
    logic signed [WW-1:0]        pb;
  } c2_t;

  typedef struct packed {
    logic signed [WW-1:0] r;
    logic                 flag;
  } c4_t;

  c1_t                   c1_d, c1_q;
  c2_t                   c2_d, c2_q, c3_d, c3_q;
  c4_t                   c4_d, c4_q;
  logic signed [OW-1:0]  c5_val_d, c5_val_q;
  logic                  c5_flag_d, c5_flag_q;
  logic [4:0]            v_q;
  logic signed [WW-1:0]  qmag;
  logic [SW:0]           sroot;
  logic signed [OPW-1:0] ts, bs;
  logic signed [WW-1:0]  tw, bw;
  logic signed [OPW-1:0] b3;

  // Stage one: signed quotient, rounded root and multiplier operands.
  always_comb begin
    ts = $signed({{(OPW-INW){1'b0}}, data_i.it.t});
    bs = $signed({{(OPW-INW){1'b0}}, data_i.it.b});
    qmag = data_i.dv.sat ? (WW'(1) <<< lbm_pkg::Q_W) : $signed(WW'(data_i.dv.q));
    sroot = (SW+1)'(data_i.sq.root) +
            (SW+1)'(SW'(data_i.sq.rem) > data_i.sq.root && data_i.sq.rem[lbm_pkg::SQ_REM_W-1 -: 3] == '0
                    || data_i.sq.rem[lbm_pkg::SQ_REM_W-1 -: 3] != '0);
    c1_d.it = data_i.it;
    c1_d.qs = data_i.dv.neg ? -qmag : qmag;
    c1_d.dz = data_i.dv.dz;
    c1_d.inv = data_i.dv.inv;
    c1_d.mrem = data_i.md.rem;
    c1_d.mzero = data_i.md.zero;
    c1_d.softlow = bs < lbm_pkg::HALF_OP;
    c1_d.pa_a = ts;
    c1_d.pa_b = bs;
    unique case (data_i.it.mode)
      lbm_pkg::MODE_SCREEN: begin
        c1_d.pa_a = lbm_pkg::ONE_OP - ts;
        c1_d.pa_b = lbm_pkg::ONE_OP - bs;
      end
      lbm_pkg::MODE_OVERLAY: begin
        if (ts < lbm_pkg::HALF_OP) begin
          c1_d.pa_a = ts <<< 1;
        end else begin
          c1_d.pa_a = (lbm_pkg::ONE_OP - ts) <<< 1;
          c1_d.pa_b = lbm_pkg::ONE_OP - bs;
        end
      end
      lbm_pkg::MODE_HARDLIGHT: begin
        if (bs < lbm_pkg::HALF_OP) begin
          c1_d.pa_a = ts <<< 1;
        end else begin
          c1_d.pa_a = (lbm_pkg::ONE_OP - ts) <<< 1;
          c1_d.pa_b = lbm_pkg::ONE_OP - bs;
        end
      end
      lbm_pkg::MODE_SOFTLIGHT: begin
        c1_d.pa_a = ts <<< 1;
        if (bs >= lbm_pkg::HALF_OP) begin
          c1_d.pa_b = lbm_pkg::ONE_OP - bs;
        end
      end
      lbm_pkg::MODE_EXCLUSION: begin
        c1_d.pa_a = (ts <<< 1) - lbm_pkg::ONE_OP;
        c1_d.pa_b = bs - lbm_pkg::HALF_OP;
      end
      default: begin
        c1_d.pa_a = ts;
      end
    endcase
    if (bs < lbm_pkg::HALF_OP) begin
      c1_d.pb_a = ts;
      c1_d.pb_b = ts;
    end else begin
      c1_d.pb_a = $signed(OPW'(sroot));
      c1_d.pb_b = (bs <<< 1) - lbm_pkg::ONE_OP;
    end
  end

  // Stage two: the two independent products.
  always_comb begin
    c2_d.it = c1_q.it;
    c2_d.qs = c1_q.qs;
    c2_d.dz = c1_q.dz;
    c2_d.inv = c1_q.inv;
    c2_d.mrem = c1_q.mrem;
    c2_d.mzero = c1_q.mzero;
    c2_d.softlow = c1_q.softlow;
    c2_d.pa = lbm_pkg::mulq_f(c1_q.pa_a, c1_q.pa_b);
    c2_d.pb = lbm_pkg::mulq_f(c1_q.pb_a, c1_q.pb_b);
  end

  // Stage three: soft light scales the squared base by one minus twice the blend.
  always_comb begin
    b3 = $signed({{(OPW-INW){1'b0}}, c2_q.it.b});
    c3_d = c2_q;
    if (c2_q.softlow) begin
      c3_d.pb = lbm_pkg::mulq_f(OPW'(c2_q.pb), lbm_pkg::ONE_OP - (b3 <<< 1));
    end
  end

  // Stage four: per-mode result.
  always_comb begin
    tw = $signed({{(WW-INW){1'b0}}, c3_q.it.t});
    bw = $signed({{(WW-INW){1'b0}}, c3_q.it.b});
    c4_d.flag = c3_q.dz || (c3_q.it.mode == lbm_pkg::MODE_MODULO && c3_q.mzero);
    unique case (c3_q.it.mode)
      lbm_pkg::MODE_MULTIPLY:   c4_d.r = c3_q.pa;
      lbm_pkg::MODE_DARKEN:     c4_d.r = (tw < bw) ? tw : bw;
      lbm_pkg::MODE_COLORBURN, lbm_pkg::MODE_COLORDODGE,
      lbm_pkg::MODE_VIVID, lbm_pkg::MODE_DIVIDE: begin
        c4_d.r = c3_q.inv ? (lbm_pkg::ONE_W - c3_q.qs) : c3_q.qs;
      end
      lbm_pkg::MODE_LINEARBURN: c4_d.r = tw + bw - lbm_pkg::ONE_W;
      lbm_pkg::MODE_LIGHTEN:    c4_d.r = (tw > bw) ? tw : bw;
      lbm_pkg::MODE_SCREEN:     c4_d.r = lbm_pkg::ONE_W - c3_q.pa;
      lbm_pkg::MODE_ADD:        c4_d.r = tw + bw;
      lbm_pkg::MODE_OVERLAY: begin
        c4_d.r = (tw < lbm_pkg::HALF_W) ? c3_q.pa : (lbm_pkg::ONE_W - c3_q.pa);
      end
      lbm_pkg::MODE_HARDLIGHT: begin
        c4_d.r = (bw < lbm_pkg::HALF_W) ? c3_q.pa : (lbm_pkg::ONE_W - c3_q.pa);
      end
      lbm_pkg::MODE_SOFTLIGHT:  c4_d.r = c3_q.pa + c3_q.pb;
      lbm_pkg::MODE_LINEARLIGHT: c4_d.r = tw + (bw <<< 1) - lbm_pkg::ONE_W;
      lbm_pkg::MODE_PINLIGHT: begin
        if (bw > lbm_pkg::HALF_W) begin
          c4_d.r = (tw > ((bw <<< 1) - lbm_pkg::ONE_W)) ? tw : ((bw <<< 1) - lbm_pkg::ONE_W);
        end else begin
          c4_d.r = (tw < (bw <<< 1)) ? tw : (bw <<< 1);
        end
      end
      lbm_pkg::MODE_MODULO: begin
        c4_d.r = c3_q.mzero ? '0 : $signed(WW'(lbm_pkg::MOD_TAB[c3_q.mrem]));
      end
      lbm_pkg::MODE_DIFFERENCE: c4_d.r = (bw > tw) ? (bw - tw) : (tw - bw);
      lbm_pkg::MODE_EXCLUSION:  c4_d.r = lbm_pkg::HALF_W - c3_q.pa;
      lbm_pkg::MODE_SUBTRACT:   c4_d.r = tw - bw;
      default:                  c4_d.r = tw;
    endcase
  end

  // Stage five: clamp to the output range.
  always_comb begin
    c5_flag_d = c4_q.flag;
    c5_val_d = OW'(c4_q.r);
    if (c4_q.r > lbm_pkg::OUT_MAX_W) begin
      c5_val_d = OW'(lbm_pkg::OUT_MAX_W);
      c5_flag_d = 1'b1;
    end else if (c4_q.r < lbm_pkg::OUT_MIN_W) begin
      c5_val_d = OW'(lbm_pkg::OUT_MIN_W);
      c5_flag_d = 1'b1;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], vld_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= c1_d;
      c2_q <= c2_d;
      c3_q <= c3_d;
      c4_q <= c4_d;
      c5_val_q <= c5_val_d;
      c5_flag_q <= c5_flag_d;
    end
  end

  assign vld_o = v_q[4];
  assign value_o = c5_val_q;
  assign sat_o = c5_flag_q;

endmodule

[hw/rtl/layer_blend_mode_channel_top.sv]
// Throughput: one word per cycle while the skid stage is empty; the 21-stage
// quotient pipeline, with the root and modulo digits riding in its first stages,
// keeps every stage busy each cycle.
// A full output register plus a one-word skid stage decouple the two sides.
// Reset clears all valid bits and sets the blend mode to passthrough.
// Top level of the per-channel layer blend.
module layer_blend_mode_channel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] base_value, [31:16] layer_value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [20:0] blended_value, [23:21] zero
  output logic        m_axis_tuser_o   // [0] saturated
);

  `include "layer_blend_mode_channel_top_assert.svh"

  localparam int OW = lbm_pkg::OUT_W;

  logic [4:0]                blend_mode_q;
  logic                      en;
  lbm_pkg::item_t            item;
  logic                      prep_vld, chain_vld, pipe_vld;
  lbm_pkg::chain_t           prep_data, chain_data;
  logic signed [OW-1:0]      pipe_val;
  logic                      pipe_sat;
  logic                      out_free;
  logic                      m_vld_q, m_vld_d;
  logic [OW-1:0]             m_val_q, m_val_d;
  logic                      m_sat_q, m_sat_d;
  logic                      skid_vld_q, skid_vld_d;
  logic [OW-1:0]             skid_val_q;
  logic                      skid_sat_q;
  logic                      skid_load;

  // Blend mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= 5'(lbm_pkg::MODE_PASS);
    end else if (cfg_we_i) begin
      blend_mode_q <= cfg_wdata_i;
    end
  end

  // The pipeline moves whenever the skid stage is empty.
  assign en = !skid_vld_q;
  assign s_axis_tready_o = en;

  assign item.t = s_axis_tdata_i[15:0];
  assign item.b = s_axis_tdata_i[31:16];
  assign item.mode = lbm_pkg::mode_e'(blend_mode_q);

  lbm_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .item_i (item),
    .vld_o  (prep_vld),
    .data_o (prep_data)
  );

  lbm_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_vld),
    .data_i (prep_data),
    .vld_o  (chain_vld),
    .data_o (chain_data)
  );

  lbm_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (chain_vld),
    .data_i  (chain_data),
    .vld_o   (pipe_vld),
    .value_o (pipe_val),
    .sat_o   (pipe_sat)
  );

  // Output register and skid stage.
  always_comb begin
    out_free = !m_vld_q || m_axis_tready_i;
    m_vld_d = m_vld_q;
    m_val_d = m_val_q;
    m_sat_d = m_sat_q;
    skid_vld_d = skid_vld_q;
    skid_load = 1'b0;
    if (skid_vld_q) begin
      if (out_free) begin
        m_vld_d = 1'b1;
        m_val_d = skid_val_q;
        m_sat_d = skid_sat_q;
        skid_vld_d = 1'b0;
      end
    end else if (out_free) begin
      m_vld_d = pipe_vld;
      m_val_d = pipe_val;
      m_sat_d = pipe_sat;
    end else if (pipe_vld) begin
      skid_vld_d = 1'b1;
      skid_load = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_val_q <= m_val_d;
    m_sat_q <= m_sat_d;
    if (skid_load) begin
      skid_val_q <= pipe_val;
      skid_sat_q <= pipe_sat;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o = {3'b000, m_val_q};
  assign m_axis_tuser_o = m_sat_q;

  // A parked word in the skid stage always has a word ahead of it at the output.
  `LBM_ASSERT_NOW(a_skid_behind_out, skid_vld_q, m_vld_q, "skid word without output word")

  // A result leaving the pipeline into a blocked output must be parked.
  `LBM_ASSERT_NEXT(a_blocked_result_parked,
                   en && pipe_vld && m_vld_q && !m_axis_tready_i, skid_vld_q,
                   "result dropped while output stalled")

  // A flagged result is a clamp bound or the zero of a modulo by zero.
  `LBM_ASSERT_NOW(a_flag_value,
                  m_vld_q && m_sat_q,
                  m_val_q == OW'(lbm_pkg::OUT_MAX_W) || m_val_q == OW'(lbm_pkg::OUT_MIN_W) ||
                  m_val_q == '0,
                  "saturated flag on an unclamped value")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the per-channel layer blend block.
`timescale 1ns / 1ps

// Holds the predicted blend results and compares them with the output words.
class blend_scoreboard;
  typedef struct {
    logic [20:0] blended;
    logic        sat;
  } blend_result_t;

  blend_result_t pending[$];
  logic [4:0]    mode;
  int            errors;

  function new();
    mode = lbm_pkg::MODE_PASS;
    errors = 0;
  endfunction

  // Q1.15 product, rounded to nearest with ties away from zero.
  function longint qmul(longint a, longint b);
    longint ma;
    longint mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + 16384) >> 15;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  // Q1.15 quotient; a zero divisor yields a huge value with the numerator's sign.
  function longint qdiv(longint n, longint d, inout bit dz);
    longint mn;
    longint md;
    longint q;
    if (d == 0) begin
      dz = 1;
      return (n < 0) ? -(64'sd1 <<< 52) : (64'sd1 <<< 52);
    end
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    q = (mn * 32768 + md / 2) / md;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  // Root of t in Q1.15, rounded to nearest.
  function longint qsqrt(longint t);
    longint unsigned x;
    longint unsigned r;
    longint unsigned bt;
    x = longint'(t) << 15;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    if (x > r) r++;
    return longint'(r);
  endfunction

  // Predicts the result of one accepted word and queues it.
  function void note_input(logic [15:0] base_v, logic [15:0] layer_v);
    longint t;
    longint b;
    longint r;
    longint ht;
    longint hb;
    longint d;
    bit     dz;
    bit     flag;
    blend_result_t res;
    t = base_v;
    b = layer_v;
    r = t;
    dz = 0;
    flag = 0;
    case (mode)
      lbm_pkg::MODE_MULTIPLY:   r = qmul(t, b);
      lbm_pkg::MODE_DARKEN:     r = (t < b) ? t : b;
      lbm_pkg::MODE_COLORBURN:  r = 32768 - qdiv(32768 - t, b, dz);
      lbm_pkg::MODE_LINEARBURN: r = t + b - 32768;
      lbm_pkg::MODE_LIGHTEN:    r = (t > b) ? t : b;
      lbm_pkg::MODE_SCREEN:     r = 32768 - qmul(32768 - t, 32768 - b);
      lbm_pkg::MODE_COLORDODGE: r = qdiv(t, 32768 - b, dz);
      lbm_pkg::MODE_ADD:        r = t + b;
      lbm_pkg::MODE_OVERLAY:
        r = (t < 16384) ? qmul(2 * t, b) : 32768 - qmul(2 * (32768 - t), 32768 - b);
      lbm_pkg::MODE_HARDLIGHT:
        r = (b < 16384) ? qmul(2 * t, b) : 32768 - qmul(2 * (32768 - t), 32768 - b);
      lbm_pkg::MODE_SOFTLIGHT:
        if (b < 16384) r = qmul(2 * t, b) + qmul(qmul(t, t), 32768 - 2 * b);
        else r = qmul(2 * t, 32768 - b) + qmul(qsqrt(t), 2 * b - 32768);
      lbm_pkg::MODE_VIVID:
        r = (b > 16384) ? qdiv(t, 32768 - 2 * (b - 16384), dz)
                        : 32768 - qdiv(32768 - t, 2 * b, dz);
      lbm_pkg::MODE_LINEARLIGHT: r = t + 2 * b - 32768;
      lbm_pkg::MODE_PINLIGHT: begin
        if (b > 16384) r = (t > 2 * (b - 16384)) ? t : 2 * (b - 16384);
        else r = (t < 2 * b) ? t : 2 * b;
      end
      lbm_pkg::MODE_MODULO: begin
        // Operands go to whole hundredths; a zero divisor gives zero and the flag.
        ht = ((t + lbm_pkg::EPS_M) * 100) >> 15;
        hb = ((b + lbm_pkg::EPS_M) * 100) >> 15;
        if (hb == 0) begin
          r = 0;
          flag = 1;
        end else begin
          r = ((ht % hb) * 32768 + 50) / 100;
        end
      end
      lbm_pkg::MODE_DIFFERENCE: r = (b > t) ? b - t : t - b;
      lbm_pkg::MODE_EXCLUSION:  r = 16384 - qmul(2 * (t - 16384), b - 16384);
      lbm_pkg::MODE_SUBTRACT:   r = t - b;
      lbm_pkg::MODE_DIVIDE: begin
        d = (b < lbm_pkg::EPS_Q) ? lbm_pkg::EPS_Q : ((b > 32768) ? 32768 : b);
        r = qdiv(t, d, dz);
      end
      default: r = t;
    endcase
    if (dz) flag = 1;
    if (r > 1048575) begin
      r = 1048575;
      flag = 1;
    end
    if (r < -1048576) begin
      r = -1048576;
      flag = 1;
    end
    res.blended = r[20:0];
    res.sat = flag;
    pending.push_back(res);
  endfunction

  // Compares one output word with the oldest prediction.
  function void check_output(logic [20:0] blended, logic sat);
    blend_result_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected output word: blended_value %h saturated %b", blended, sat);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (blended !== exp_r.blended) begin
      $error("blended_value: expected %h, actual %h", exp_r.blended, blended);
      errors++;
    end
    if (sat !== exp_r.sat) begin
      $error("saturated: expected %b, actual %b", exp_r.sat, sat);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;  // [15:0] base_value, [31:16] layer_value
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // [20:0] blended_value, [23:21] zero
  logic        m_axis_tuser_o;       // [0] saturated

  blend_scoreboard blend_sb = new();
  bit              calm = 0;
  int              stall_left = 0;

  layer_blend_mode_channel_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short pauses with an occasional long one; none in calm phases.
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Output-side backpressure.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      stall_left <= pause_len();
      m_axis_tready_i <= 1'b1;
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      blend_sb.check_output(m_axis_tdata_o[20:0], m_axis_tuser_o);
    end
  end

  // Sends one word and waits for it to be taken.
  task automatic send_word(logic [15:0] base_v, logic [15:0] layer_v);
    int gap;
    s_axis_tdata_i <= {layer_v, base_v};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    blend_sb.note_input(base_v, layer_v);
    gap = pause_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drains the pipeline and then writes the blend mode.
  task automatic write_mode(logic [4:0] mode);
    s_axis_tvalid_i <= 1'b0;
    while (blend_sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    blend_sb.mode = mode;
  endtask

  // Random channel value: mostly in range, some near the break points, some full width.
  function automatic logic [15:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 32768));
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 16'($urandom_range(0, 400));
        1: return 16'($urandom_range(16382, 16386));
        2: return 16'($urandom_range(32764, 32772));
        default: return 16'($urandom_range(65530, 65535));
      endcase
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [15:0] corners [10];
    logic [4:0]  mode;
    corners = '{16'd0, 16'd32768, 16'd16384, 16'd16383, 16'd16385, 16'd65535,
                16'd1, 16'd32767, 16'd200, 16'd400};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pairs of extreme and break-point values under every mode code.
    for (int m = 0; m < 32; m++) begin
      calm = (m % 4 == 0);
      write_mode(5'(m));
      for (int k = 0; k < 5; k++) begin
        send_word(corners[$urandom_range(0, 9)], corners[$urandom_range(0, 9)]);
      end
      if (m == lbm_pkg::MODE_PASS || m == lbm_pkg::MODE_COLORBURN ||
          m == lbm_pkg::MODE_COLORDODGE || m == lbm_pkg::MODE_VIVID ||
          m == lbm_pkg::MODE_MODULO || m == lbm_pkg::MODE_DIVIDE) begin
        send_word(16'd0, 16'd0);
        send_word(16'd32768, 16'd32768);
        send_word(16'd65535, 16'd65535);
        send_word(16'd0, 16'd16384);
      end
    end

    // Random phases, each under one mode.
    for (int p = 0; p < 28; p++) begin
      calm = (p % 5 == 2);
      if (p < 20) mode = 5'(p);
      else if (p == 20) mode = 5'd31;
      else mode = 5'($urandom_range(0, 31));
      write_mode(mode);
      for (int k = 0; k < 13; k++) send_word(rand_value(), rand_value());
    end

    s_axis_tvalid_i <= 1'b0;
    while (blend_sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (blend_sb.errors == 0) begin
      $display("layer_blend_mode_channel_top verification clean");
    end else begin
      $display("layer_blend_mode_channel_top verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("layer_blend_mode_channel_top verification failed");
    $finish;
  end
endmodule
